// ===== hdl/lfug_pkg.sv =====
`default_nettype none

package lfug_pkg;

    localparam int FRAC_W      = 24;
    localparam int SEED_W      = 8;
    localparam int COUNT_W     = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int TABLE_LEN   = 97;
    localparam int POS_W       = $clog2(TABLE_LEN);
    localparam int BIT_CNT_W   = $clog2(FRAC_W);
    localparam int STEP_W      = $clog2(SEED_W);

    localparam int MAX_BATCH_DEF = 64;

    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(TABLE_LEN - 1);
    localparam logic [POS_W-1:0] LAG_A_START = POS_W'(TABLE_LEN - 1);
    localparam logic [POS_W-1:0] LAG_B_START = POS_W'(32);

    localparam logic [FRAC_W-1:0] CARRY_START = FRAC_W'(362436);
    localparam logic [FRAC_W-1:0] CARRY_STEP  = FRAC_W'(7654321);
    localparam logic [FRAC_W-1:0] CARRY_WRAP  = FRAC_W'(16777213 - 7654321);

    localparam logic [SEED_W-1:0] MOD_PROD = SEED_W'(179);
    localparam logic [SEED_W-1:0] MOD_LCG  = SEED_W'(169);
    localparam logic [SEED_W-1:0] LCG_MULT = SEED_W'(53);
    localparam logic [SEED_W-1:0] SEED_MAX = SEED_W'(168);

    localparam logic [SEED_W-1:0] SEED_FIRST_RST  = SEED_W'(1);
    localparam logic [SEED_W-1:0] SEED_SECOND_RST = SEED_W'(2);
    localparam logic [SEED_W-1:0] SEED_THIRD_RST  = SEED_W'(3);
    localparam logic [SEED_W-1:0] SEED_FOURTH_RST = SEED_W'(4);

    localparam logic [SEED_W-1:0] SEED_FIRST_ALT  = SEED_W'(12);
    localparam logic [SEED_W-1:0] SEED_SECOND_ALT = SEED_W'(34);
    localparam logic [SEED_W-1:0] SEED_THIRD_ALT  = SEED_W'(56);
    localparam logic [SEED_W-1:0] SEED_FOURTH_ALT = SEED_W'(78);

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_SEED_FIRST  = CFG_INDEX_W'(0);
    localparam cfg_index_t REG_SEED_SECOND = CFG_INDEX_W'(1);
    localparam cfg_index_t REG_SEED_THIRD  = CFG_INDEX_W'(2);
    localparam cfg_index_t REG_SEED_FOURTH = CFG_INDEX_W'(3);

    typedef struct packed {
        logic               reseed;
        logic [COUNT_W-1:0] count;
    } req_item_t;

    typedef struct packed {
        logic [FRAC_W-1:0] value;
        logic              last;
    } res_item_t;

    typedef struct packed {
        logic [SEED_W-1:0] a;
        logic [SEED_W-1:0] b;
        logic [SEED_W-1:0] c;
        logic [SEED_W-1:0] lcg;
    } seed_set_t;

    typedef struct packed {
        logic              en;
        logic [POS_W-1:0]  addr;
        logic [FRAC_W-1:0] data;
    } lag_wr_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_AB,
        FS_RC,
        FS_LCG,
        FS_INC,
        FS_BIT
    } fill_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_DRAW
    } top_state_t;

endpackage

`default_nettype wire

// ===== hdl/lfug_fill.sv =====
`default_nettype none

module lfug_fill (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire lfug_pkg::seed_set_t  seeds,
    output lfug_pkg::lag_wr_t         wr,
    output logic                      done
);
    import lfug_pkg::*;

    localparam logic [STEP_W-1:0]    STEP_LAST = STEP_W'(SEED_W - 1);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST  = BIT_CNT_W'(FRAC_W - 1);

    fill_state_t state_reg, state_next;

    logic [SEED_W-1:0]    mix_a_reg, mix_b_reg, mix_c_reg, lcg_reg;
    logic [SEED_W-1:0]    acc_reg, x_reg, y_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [POS_W-1:0]     entry_reg;
    logic [FRAC_W-1:0]    word_reg;

    // shared modular step: acc' = (2*acc + x_msb*y) mod M, or (acc + 1) mod M in FS_INC
    logic                 unit_dbl;
    logic                 unit_add;
    logic [SEED_W-1:0]    unit_y;
    logic [SEED_W-1:0]    unit_mod;
    logic [SEED_W+1:0]    unit_sum;
    logic [SEED_W+1:0]    unit_mod_x2;
    logic [SEED_W-1:0]    unit_res;

    logic                 step_last;
    logic                 word_last;
    logic [2*6-1:0]       bit_prod;
    logic                 new_bit;

    assign step_last = (step_reg == STEP_LAST);
    assign word_last = (bit_cnt_reg == BIT_LAST);
    assign bit_prod  = lcg_reg[5:0] * mix_c_reg[5:0];
    assign new_bit   = bit_prod[5];

    always_comb
    begin
        unit_sum = (unit_dbl ? {1'b0, acc_reg, 1'b0} : {2'b00, acc_reg})
                 + (unit_add ? {2'b00, unit_y} : '0);
        unit_mod_x2 = {1'b0, unit_mod, 1'b0};
        if (unit_sum >= unit_mod_x2)
        begin
            unit_res = SEED_W'(unit_sum - unit_mod_x2);
        end
        else if (unit_sum >= {2'b00, unit_mod})
        begin
            unit_res = SEED_W'(unit_sum - {2'b00, unit_mod});
        end
        else
        begin
            unit_res = SEED_W'(unit_sum);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE: if (start) state_next = FS_AB;
            FS_AB:   if (step_last) state_next = FS_RC;
            FS_RC:   if (step_last) state_next = FS_LCG;
            FS_LCG:  if (step_last) state_next = FS_INC;
            FS_INC:  state_next = FS_BIT;
            FS_BIT:
            begin
                if (word_last && entry_reg == POS_LAST)
                    state_next = FS_IDLE;
                else
                    state_next = FS_AB;
            end
            default: state_next = FS_IDLE;
        endcase
    end

    always_comb
    begin
        unit_dbl = 1'b1;
        unit_add = x_reg[SEED_W-1];
        unit_y   = y_reg;
        unit_mod = MOD_PROD;
        wr.en    = 1'b0;
        wr.addr  = entry_reg;
        wr.data  = {word_reg[FRAC_W-2:0], new_bit};
        done     = 1'b0;
        unique case (state_reg)
            FS_LCG:
            begin
                unit_mod = MOD_LCG;
            end
            FS_INC:
            begin
                unit_dbl = 1'b0;
                unit_add = 1'b1;
                unit_y   = SEED_W'(1);
                unit_mod = MOD_LCG;
            end
            FS_BIT:
            begin
                wr.en = word_last;
                done  = word_last && (entry_reg == POS_LAST);
            end
            default:
            begin
                unit_mod = MOD_PROD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            mix_a_reg <= '0;
            mix_b_reg <= '0;
            mix_c_reg <= '0;
            lcg_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                FS_IDLE:
                begin
                    if (start)
                    begin
                        mix_a_reg <= seeds.a;
                        mix_b_reg <= seeds.b;
                        mix_c_reg <= seeds.c;
                        lcg_reg   <= seeds.lcg;
                    end
                end
                FS_RC:
                begin
                    if (step_last)
                    begin
                        mix_a_reg <= mix_b_reg;
                        mix_b_reg <= mix_c_reg;
                        mix_c_reg <= unit_res;
                    end
                end
                FS_INC:
                begin
                    lcg_reg <= unit_res;
                end
                default:
                begin
                    lcg_reg <= lcg_reg;
                end
            endcase
        end
    end

    // working registers of the shared unit and the word assembly
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            FS_IDLE:
            begin
                x_reg       <= seeds.a;
                y_reg       <= seeds.b;
                acc_reg     <= '0;
                step_reg    <= '0;
                bit_cnt_reg <= '0;
                entry_reg   <= '0;
                word_reg    <= '0;
            end
            FS_AB, FS_RC, FS_LCG:
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_last)
                begin
                    if (state_reg == FS_AB)
                    begin
                        acc_reg <= '0;
                        x_reg   <= unit_res;
                        y_reg   <= mix_c_reg;
                    end
                    else if (state_reg == FS_RC)
                    begin
                        acc_reg <= '0;
                        x_reg   <= LCG_MULT;
                        y_reg   <= lcg_reg;
                    end
                    else
                    begin
                        acc_reg <= unit_res;
                    end
                end
                else
                begin
                    acc_reg <= unit_res;
                    x_reg   <= {x_reg[SEED_W-2:0], 1'b0};
                end
            end
            FS_INC:
            begin
                acc_reg <= '0;
            end
            FS_BIT:
            begin
                word_reg <= {word_reg[FRAC_W-2:0], new_bit};
                x_reg    <= mix_a_reg;
                y_reg    <= mix_b_reg;
                acc_reg  <= '0;
                step_reg <= '0;
                if (word_last)
                begin
                    bit_cnt_reg <= '0;
                    entry_reg   <= entry_reg + POS_W'(1);
                end
                else
                begin
                    bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/lfug_lagmem.sv =====
`default_nettype none

module lfug_lagmem (
    input  wire                             clk,
    input  wire lfug_pkg::lag_wr_t          wr,
    input  wire                             rd_en,
    input  wire  [lfug_pkg::POS_W-1:0]      rd_addr_a,
    input  wire  [lfug_pkg::POS_W-1:0]      rd_addr_b,
    output logic [lfug_pkg::FRAC_W-1:0]     rd_data_a,
    output logic [lfug_pkg::FRAC_W-1:0]     rd_data_b
);
    import lfug_pkg::*;

    logic [FRAC_W-1:0] mem [TABLE_LEN];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lagged_fibonacci_uniform_generator.sv =====
`default_nettype none

// Lagged-Fibonacci uniform generator with Weyl carry (97-entry table, 0.24 fixed point).
// A request is taken only while the block is idle; it returns count values (saturated
// to MAX_BATCH, none for a count of zero), the final one flagged by last. The first
// request after reset, and any request with reseed set, first rebuilds the table from
// the four seed registers: one shared mod-179/mod-169 shift-add unit makes each table
// bit in turn through the states AB, RC, LCG, INC and BIT. Then values are made one at
// a time: both lag entries are read from the two-port table, then the block subtracts,
// writes back and loads the output register, which a stalled consumer holds.
// Seed writes take effect at the next rebuild; out-of-range seeds fall back to a fixed set.
module lagged_fibonacci_uniform_generator #(
    parameter int MAX_BATCH = lfug_pkg::MAX_BATCH_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               req_valid,
    output logic                              req_ready,
    input  wire lfug_pkg::req_item_t          req_data,
    output logic                              res_valid,
    input  wire                               res_ready,
    output lfug_pkg::res_item_t               res_data,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [lfug_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [lfug_pkg::SEED_W-1:0]       cfg_data
);
    import lfug_pkg::*;

    localparam int REM_W = $clog2(MAX_BATCH + 1);
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_BATCH);

    top_state_t state_reg, state_next;

    logic [SEED_W-1:0] seed_first_reg, seed_second_reg, seed_third_reg, seed_fourth_reg;
    logic              table_ready_reg;
    logic [POS_W-1:0]  pos_a_reg, pos_b_reg;
    logic [FRAC_W-1:0] carry_reg;
    logic [REM_W-1:0]  rem_reg;
    logic              res_valid_reg;
    res_item_t         res_data_reg;

    logic              req_fire;
    logic              need_fill;
    logic [COUNT_W-1:0] count_sat;
    logic              draw_fire;
    logic              read_en;
    logic              fill_start;
    logic              fill_done;
    logic              seeds_ok;
    seed_set_t         seeds;
    lag_wr_t           fill_wr;
    lag_wr_t           draw_wr;
    lag_wr_t           mem_wr;
    logic [FRAC_W-1:0] rd_data_a, rd_data_b;
    logic [FRAC_W-1:0] lag_diff;
    logic [FRAC_W-1:0] carry_next;
    logic              rem_last;

    assign req_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    assign req_fire  = req_valid && req_ready;
    assign need_fill = !table_ready_reg || req_data.reseed;
    assign count_sat = (req_data.count > MAX_CNT) ? MAX_CNT : req_data.count;
    assign rem_last  = (rem_reg == REM_W'(1));

    always_comb
    begin
        seeds_ok = 1'b1;
        if (seed_first_reg == '0 || seed_first_reg > SEED_MAX) seeds_ok = 1'b0;
        if (seed_second_reg == '0 || seed_second_reg > SEED_MAX) seeds_ok = 1'b0;
        if (seed_third_reg == '0 || seed_third_reg > SEED_MAX) seeds_ok = 1'b0;
        if (seed_fourth_reg == '0 || seed_fourth_reg > SEED_MAX) seeds_ok = 1'b0;
        if (seed_first_reg == SEED_W'(1) && seed_second_reg == SEED_W'(1)
            && seed_third_reg == SEED_W'(1) && seed_fourth_reg == SEED_W'(1))
            seeds_ok = 1'b0;
        if (seeds_ok)
            seeds = '{a: seed_first_reg, b: seed_second_reg,
                      c: seed_third_reg, lcg: seed_fourth_reg};
        else
            seeds = '{a: SEED_FIRST_ALT, b: SEED_SECOND_ALT,
                      c: SEED_THIRD_ALT, lcg: SEED_FOURTH_ALT};
    end

    // lagged subtraction and Weyl carry
    assign lag_diff   = rd_data_a - rd_data_b;
    assign carry_next = (carry_reg < CARRY_STEP) ? carry_reg + CARRY_WRAP
                                                 : carry_reg - CARRY_STEP;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (need_fill)
                        state_next = ST_FILL;
                    else if (count_sat != '0)
                        state_next = ST_READ;
                end
            end
            ST_FILL:
            begin
                if (fill_done)
                    state_next = (rem_reg == '0) ? ST_IDLE : ST_READ;
            end
            ST_READ: state_next = ST_DRAW;
            ST_DRAW:
            begin
                if (draw_fire)
                    state_next = rem_last ? ST_IDLE : ST_READ;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        fill_start = 1'b0;
        read_en    = 1'b0;
        draw_fire  = 1'b0;
        unique case (state_reg)
            ST_IDLE: fill_start = req_fire && need_fill;
            ST_READ: read_en = 1'b1;
            ST_DRAW: draw_fire = !res_valid_reg || res_ready;
            default: fill_start = 1'b0;
        endcase
        draw_wr.en   = draw_fire;
        draw_wr.addr = pos_a_reg;
        draw_wr.data = lag_diff;
        mem_wr       = fill_wr.en ? fill_wr : draw_wr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            seed_first_reg  <= SEED_FIRST_RST;
            seed_second_reg <= SEED_SECOND_RST;
            seed_third_reg  <= SEED_THIRD_RST;
            seed_fourth_reg <= SEED_FOURTH_RST;
            table_ready_reg <= 1'b0;
            pos_a_reg       <= LAG_A_START;
            pos_b_reg       <= LAG_B_START;
            carry_reg       <= CARRY_START;
            rem_reg         <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SEED_FIRST:  seed_first_reg  <= cfg_data;
                    REG_SEED_SECOND: seed_second_reg <= cfg_data;
                    REG_SEED_THIRD:  seed_third_reg  <= cfg_data;
                    REG_SEED_FOURTH: seed_fourth_reg <= cfg_data;
                    default:         seed_first_reg  <= seed_first_reg;
                endcase
            end

            if (req_fire)
            begin
                rem_reg <= REM_W'(count_sat);
            end

            if (fill_done)
            begin
                table_ready_reg <= 1'b1;
                pos_a_reg       <= LAG_A_START;
                pos_b_reg       <= LAG_B_START;
                carry_reg       <= CARRY_START;
            end

            if (draw_fire)
            begin
                pos_a_reg     <= (pos_a_reg == '0) ? POS_LAST : pos_a_reg - POS_W'(1);
                pos_b_reg     <= (pos_b_reg == '0) ? POS_LAST : pos_b_reg - POS_W'(1);
                carry_reg     <= carry_next;
                rem_reg       <= rem_reg - REM_W'(1);
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (draw_fire)
        begin
            res_data_reg.value <= lag_diff - carry_next;
            res_data_reg.last  <= rem_last;
        end
    end

    lfug_fill u_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fill_start),
        .seeds (seeds),
        .wr    (fill_wr),
        .done  (fill_done)
    );

    lfug_lagmem u_lagmem (
        .clk       (clk),
        .wr        (mem_wr),
        .rd_en     (read_en),
        .rd_addr_a (pos_a_reg),
        .rd_addr_b (pos_b_reg),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

endmodule

`default_nettype wire

// ===== hdl/lfug_checker.sv =====
`default_nettype none

module lfug_checker (
    input wire                       clk,
    input wire                       rst_n,
    input wire                       req_valid,
    input wire                       req_ready,
    input wire lfug_pkg::req_item_t  req_data,
    input wire                       res_valid,
    input wire                       res_ready,
    input wire lfug_pkg::res_item_t  res_data
);
    import lfug_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed or dropped while stalled");

    // no new request while a run still has values to come
    a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.last |-> !req_ready)
        else $error("request taken in the middle of a run");

    // a request with values to give blocks the next one
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_data.count != '0 |=> !req_ready)
        else $error("ready stayed high after a request with values");

    // an idle block empties its output once the final value is taken
    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_data.last && req_ready |=> !res_valid)
        else $error("result shown right after the final transfer of a run");

endmodule

bind lagged_fibonacci_uniform_generator lfug_checker u_lfug_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

`default_nettype wire

// ===== bench/lagged_fibonacci_uniform_generator_tb.sv =====
`timescale 1ns / 1ps

module lagged_fibonacci_uniform_generator_tb;
    import lfug_pkg::*;

    localparam int LAG_LEN    = 97;
    localparam int LAG_B_HOME = 32;
    localparam int SEED_HI    = 168;
    localparam int WEYL_START = 362436;
    localparam int WEYL_STEP  = 7654321;
    localparam int WEYL_WRAP  = 16777213;
    localparam int RUN_LIMIT  = 4_000_000;

    localparam cfg_index_t REG_SPARE_FIRST = cfg_index_t'(REG_SEED_FOURTH + 1);
    localparam cfg_index_t REG_SPARE_LAST  = '1;

    typedef struct packed {
        cfg_index_t        index;
        logic [SEED_W-1:0] data;
    } reg_write_t;

    class ranmar_tracker;
        bit [SEED_W-1:0] seed_a, seed_b, seed_c, seed_lcg;
        bit [FRAC_W-1:0] lag [LAG_LEN];
        int unsigned     idx_a, idx_b;
        int unsigned     weyl;
        bit              filled;
        res_item_t       awaited [$];
        int unsigned     requests, values, rebuilds, errors;

        function new();
            seed_a   = 1;
            seed_b   = 2;
            seed_c   = 3;
            seed_lcg = 4;
            idx_a    = LAG_LEN - 1;
            idx_b    = LAG_B_HOME;
            weyl     = WEYL_START;
            filled   = 0;
        endfunction

        function void report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endfunction

        function void set_register(cfg_index_t index, logic [SEED_W-1:0] data);
            case (index)
                REG_SEED_FIRST:  seed_a   = data;
                REG_SEED_SECOND: seed_b   = data;
                REG_SEED_THIRD:  seed_c   = data;
                REG_SEED_FOURTH: seed_lcg = data;
                default: ;
            endcase
        endfunction

        function bit seeds_ok();
            if (seed_a < 1 || seed_a > SEED_HI || seed_b < 1 || seed_b > SEED_HI)
                return 0;
            if (seed_c < 1 || seed_c > SEED_HI || seed_lcg < 1 || seed_lcg > SEED_HI)
                return 0;
            return !(seed_a == 1 && seed_b == 1 && seed_c == 1 && seed_lcg == 1);
        endfunction

        function void rebuild();
            int unsigned     a, b, c, g, m;
            bit [FRAC_W-1:0] word;
            if (seeds_ok()) begin
                a = seed_a;
                b = seed_b;
                c = seed_c;
                g = seed_lcg;
            end
            else begin
                a = 12;
                b = 34;
                c = 56;
                g = 78;
            end
            for (int e = 0; e < LAG_LEN; e++) begin
                word = '0;
                for (int n = 0; n < FRAC_W; n++) begin
                    m = (((a * b) % 179) * c) % 179;
                    a = b;
                    b = c;
                    c = m;
                    g = (53 * g + 1) % 169;
                    // msb first: the bit is set in the upper half of mod 64
                    word = {word[FRAC_W-2:0], ((g * m) % 64) >= 32};
                end
                lag[e] = word;
            end
            idx_a  = LAG_LEN - 1;
            idx_b  = LAG_B_HOME;
            weyl   = WEYL_START;
            filled = 1;
            rebuilds++;
        endfunction

        function void take_request(req_item_t req);
            int unsigned     n;
            bit [FRAC_W-1:0] u;
            res_item_t       r;
            requests++;
            n = (req.count > MAX_BATCH_DEF) ? MAX_BATCH_DEF : req.count;
            if (!filled || req.reseed)
                rebuild();
            for (int k = 0; k < n; k++) begin
                u = lag[idx_a] - lag[idx_b];
                lag[idx_a] = u;
                idx_a = (idx_a == 0) ? LAG_LEN - 1 : idx_a - 1;
                idx_b = (idx_b == 0) ? LAG_LEN - 1 : idx_b - 1;
                weyl = (weyl < WEYL_STEP) ? weyl + (WEYL_WRAP - WEYL_STEP) : weyl - WEYL_STEP;
                r.value = u - FRAC_W'(weyl);
                r.last  = (k == n - 1);
                awaited.push_back(r);
            end
        endfunction

        function void check_value(res_item_t got);
            res_item_t want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected value %06h last %0b", got.value, got.last));
                return;
            end
            want = awaited.pop_front();
            values++;
            if (got.value !== want.value)
                report($sformatf("value %06h, want %06h", got.value, want.value));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b (value %06h)", got.last, want.last,
                                 want.value));
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_item_t         req_data  = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    res_item_t         res_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_index_t        cfg_index = '0;
    logic [SEED_W-1:0] cfg_data  = '0;

    int unsigned   cycles      = 0;
    int unsigned   tx_idle_max = 5;
    int unsigned   rx_idle_max = 5;
    int unsigned   rx_hold     = 0;
    int unsigned   reg_writes  = 0;
    reg_write_t    reg_plan [$];
    ranmar_tracker tracker     = new();

    lagged_fibonacci_uniform_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == RUN_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            tracker.check_value(res_data);
    end

    initial
    begin : receiver
        int unsigned gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold != 0)
            begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            else
                gap = $urandom_range(0, rx_idle_max);
            if (gap > 0)
            begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
        end
    end

    task automatic send_request(input logic reseed, input logic [COUNT_W-1:0] count);
        int unsigned gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{reseed: reseed, count: count};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        tracker.take_request(req_data);
    endtask

    // Wait out all values and any table rebuild still running, so seeds can change.
    task automatic settle();
        req_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (tracker.awaited.size() != 0 || !req_ready) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic stage_write(input cfg_index_t index, input logic [SEED_W-1:0] data);
        reg_plan.push_back('{index: index, data: data});
    endtask

    task automatic program_regs();
        reg_write_t w;
        while (reg_plan.size() != 0)
        begin
            w = reg_plan.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.index;
            cfg_data  <= w.data;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            tracker.set_register(w.index, w.data);
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned         r;
        logic                rs;
        logic [COUNT_W-1:0]  n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset seeds; the first request builds the table even without reseed
        send_request(1'b0, COUNT_W'(1));
        send_request(1'b0, COUNT_W'(64));
        send_request(1'b0, COUNT_W'(127));
        send_request(1'b0, COUNT_W'(0));
        send_request(1'b0, COUNT_W'(65));
        send_request(1'b0, COUNT_W'(2));
        settle();

        // top seeds plus writes to unused indexes; no rebuild until reseed
        stage_write(REG_SEED_FIRST, SEED_W'(SEED_HI));
        stage_write(REG_SEED_SECOND, SEED_W'(SEED_HI));
        stage_write(REG_SEED_THIRD, SEED_W'(SEED_HI));
        stage_write(REG_SEED_FOURTH, SEED_W'(SEED_HI));
        stage_write(REG_SPARE_FIRST, '1);
        stage_write(REG_SPARE_LAST, '0);
        program_regs();
        send_request(1'b0, COUNT_W'(5));
        send_request(1'b1, COUNT_W'(3));
        send_request(1'b0, COUNT_W'(100));
        settle();

        // all ones falls back to the fixed seed set
        stage_write(REG_SEED_FIRST, SEED_W'(1));
        stage_write(REG_SEED_SECOND, SEED_W'(1));
        stage_write(REG_SEED_THIRD, SEED_W'(1));
        stage_write(REG_SEED_FOURTH, SEED_W'(1));
        program_regs();
        send_request(1'b1, COUNT_W'(10));
        send_request(1'b0, COUNT_W'(1));
        settle();

        // zero seed; a reseed with no values still rebuilds
        stage_write(REG_SEED_FIRST, '0);
        program_regs();
        send_request(1'b1, COUNT_W'(0));
        send_request(1'b0, COUNT_W'(20));
        settle();

        // seeds above range
        stage_write(REG_SEED_FIRST, SEED_W'(1));
        stage_write(REG_SEED_SECOND, SEED_W'(SEED_HI + 1));
        stage_write(REG_SEED_FOURTH, '1);
        program_regs();
        send_request(1'b1, COUNT_W'(8));

        for (int p = 0; p < 4; p++)
        begin
            settle();
            for (int k = 0; k < 4; k++)
                stage_write(cfg_index_t'(REG_SEED_FIRST + k),
                            ($urandom_range(0, 4) == 0) ? SEED_W'($urandom_range(0, 255))
                                                        : SEED_W'($urandom_range(1, SEED_HI)));
            if ($urandom_range(0, 1) == 1)
                stage_write(cfg_index_t'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                            SEED_W'($urandom));
            program_regs();

            for (int i = 0; i < 88; i++)
            begin
                if (i % 22 == 0)
                begin
                    tx_idle_max = ($urandom_range(0, 1) == 1) ? 5 : 0;
                    rx_idle_max = ($urandom_range(0, 1) == 1) ? 5 : 0;
                    if (p == 2 && i == 0)
                    begin
                        tx_idle_max = 0;
                        rx_idle_max = 0;
                    end
                end
                rs = (i == 0) || ($urandom_range(0, 199) == 0);
                r  = $urandom_range(0, 99);
                if (r < 5)
                    n = '0;
                else if (r < 75)
                    n = COUNT_W'($urandom_range(1, 16));
                else if (r < 90)
                    n = COUNT_W'($urandom_range(17, 64));
                else
                    n = COUNT_W'($urandom_range(65, 127));
                // stall the output long enough to back up the request side
                if (p == 0 && i == 10)
                begin
                    rx_hold = 400;
                    n       = COUNT_W'(MAX_BATCH_DEF);
                end
                // pause the sender until every pending value has drained
                if (p == 1 && i == 40)
                begin
                    req_valid <= 1'b0;
                    @(posedge clk);
                    while (tracker.awaited.size() != 0) @(posedge clk);
                end
                send_request(rs, n);
            end
        end

        settle();
        $display("Covered %0d requests, %0d values checked, %0d table rebuilds",
                 tracker.requests, tracker.values, tracker.rebuilds);
        $display("%0d register writes, with out-of-range seeds and unused indexes",
                 reg_writes);
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
